### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FILL_W = 5;
	localparam int DATA_W = 32;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_DEQ  = 2'd1;
	localparam logic [1:0] CMD_DUMP = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] item_value;
		logic signed [DATA_W-1:0] item_priority;
	} request_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] out_value;
		logic signed [DATA_W-1:0] out_priority;
		logic [FILL_W-1:0]        fill_count;
		logic                     last;
	} result_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_POP,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     occupied;
		logic     tail;
		logic     left_ge;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

endpackage
`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted queue chain: holds an entry and moves it to or from neighbors.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
	input  wire logic              clk,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire spq_pkg::entry_t   new_entry,
	input  wire spq_pkg::entry_t   left_entry,
	input  wire spq_pkg::entry_t   right_entry,
	input  wire spq_pkg::entry_t   head_entry,
	output spq_pkg::entry_t        entry,
	output logic                   ge
);
	import spq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;

	assign entry = entry_q;
	assign ge    = ctl.occupied && (entry_q.prio >= new_entry.prio);

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			OP_INS: begin
				if (!ge) begin
					entry_d = ctl.left_ge ? new_entry : left_entry;
				end
			end
			OP_POP: entry_d = right_entry;
			OP_ROT: entry_d = ctl.tail ? head_entry : right_entry;
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue: chain of DEPTH cells kept in descending priority order.
// Depends on spq_pkg and spq_cell.
// Enqueue, dequeue and unused commands: one per cycle while not busy; each result is
// registered in the cycle after the transfer. Dump of n entries: busy while the chain
// rotates; n results, one per cycle, come after the state then result register. Results
// cannot be stalled. Reset clears count and control; entries are undefined until written.
`default_nettype none
module sorted_priority_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire spq_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output spq_pkg::result_t   result
);
	import spq_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	result_t           result_q, result_d;
	logic              done_q, done_d;
	cell_op_t          op;
	logic              accept;
	entry_t            new_entry;
	entry_t            cell_entry [DEPTH];
	logic [DEPTH-1:0]  cell_ge;

	assign busy      = (state_q == S_DUMP);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign result    = result_q;
	assign new_entry = '{value: request.item_value, prio: request.item_priority};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    left_e;
		entry_t    right_e;

		assign ctl.op       = op;
		assign ctl.occupied = (CNT_W'(i) < count_q);
		assign ctl.tail     = (CNT_W'(i) == count_q - CNT_W'(1));

		if (i == 0) begin : g_first
			assign ctl.left_ge = 1'b1;
			assign left_e      = new_entry;
		end else begin : g_mid
			assign ctl.left_ge = cell_ge[i-1];
			assign left_e      = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.head_entry  (cell_entry[0]),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && request.command == CMD_DUMP && count_q != '0) begin
					state_d = S_DUMP;
				end
			end
			S_DUMP: begin
				if (rem_q == CNT_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_HOLD;
		count_d  = count_q;
		rem_d    = rem_q;
		done_d   = 1'b0;
		result_d = '{status: STAT_OK, out_value: '0, out_priority: '0,
			fill_count: '0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (request.command)
						CMD_ENQ: begin
							if (count_q == CNT_W'(DEPTH)) begin
								result_d.status = STAT_FULL;
							end else begin
								op      = OP_INS;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_DEQ: begin
							if (count_q == '0) begin
								result_d.status = STAT_EMPTY;
							end else begin
								op                    = OP_POP;
								count_d               = count_q - CNT_W'(1);
								result_d.out_value    = cell_entry[0].value;
								result_d.out_priority = cell_entry[0].prio;
							end
						end
						CMD_DUMP: begin
							if (count_q == '0) begin
								result_d.status = STAT_EMPTY;
							end else begin
								done_d = 1'b0;
								rem_d  = count_q;
							end
						end
						default: result_d.status = STAT_OK;
					endcase
				end
			end
			S_DUMP: begin
				op                    = OP_ROT;
				done_d                = 1'b1;
				rem_d                 = rem_q - CNT_W'(1);
				result_d.out_value    = cell_entry[0].value;
				result_d.out_priority = cell_entry[0].prio;
				result_d.last         = (rem_q == CNT_W'(1));
			end
			default: op = OP_HOLD;
		endcase
		result_d.fill_count = FILL_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

endmodule
`default_nettype wire
